// ----- rtl/core/c_comment_line_classifier_unit_macros.svh -----
// Assertion macros used by the checker file of the comment line classifier.
// Self-contained; expects a clock and an active-low reset to be passed in.
`ifndef C_COMMENT_LINE_CLASSIFIER_UNIT_MACROS_SVH
`define C_COMMENT_LINE_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("comment classifier check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("comment classifier check failed");

`endif

// ----- rtl/core/ccl_pkg.sv -----
// Shared types and constants of the comment line classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package ccl_pkg;

	// Command codes of an input beat. Code 3 is unused and ignored.
	localparam logic [1:0] CMD_CHAR  = 2'd0;
	localparam logic [1:0] CMD_EMPTY = 2'd1;
	localparam logic [1:0] CMD_EOF   = 2'd2;

	// Characters that matter to the scanner.
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_NUL       = 8'h00;

	// Position of the next character within its line.
	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_LATER  = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] ch;
		logic       line_end;
	} item_t;

	typedef struct packed {
		logic emit;
		logic is_comment;
	} scan_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/ccl_in_reg.sv -----
// Input register stage of the comment line classifier.
// Depends on ccl_pkg for the item type.
`default_nettype none

module ccl_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ccl_pkg::item_t item,
	input  logic          advance,
	output logic          valid_s1,
	output ccl_pkg::item_t item_s1
);
	import ccl_pkg::*;

	logic load;

	// The stage takes a new beat whenever it is empty or its beat moves on.
	assign in_stall = valid_s1 && !advance;
	assign load     = !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ccl_scan.sv -----
// Scanner state and per-character update of the comment line classifier.
// Depends on ccl_pkg for codes, characters and the item and result types.
`default_nettype none

module ccl_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  ccl_pkg::item_t    item_s1,
	input  logic              fire,
	output ccl_pkg::scan_res_t res
);
	import ccl_pkg::*;

	logic       block_q, in_string_q, line_comment_q;
	logic [7:0] prev_q;
	logic [1:0] pos_q;

	logic       block_d, in_string_d, line_comment_d;
	logic [7:0] prev_d;
	logic [1:0] pos_d;

	always_comb begin
		logic lc;
		logic str;
		logic blk;
		block_d        = block_q;
		in_string_d    = in_string_q;
		line_comment_d = line_comment_q;
		prev_d         = prev_q;
		pos_d          = pos_q;
		res            = '0;
		lc             = line_comment_q;
		str            = in_string_q;
		blk            = block_q;
		unique case (item_s1.cmd)
			CMD_CHAR: begin
				if (pos_q == POS_FIRST) begin
					// The first character is only remembered, never scanned.
					lc     = 1'b0;
					str    = 1'b0;
					pos_d  = POS_SECOND;
				end else begin
					if (pos_q == POS_SECOND) begin
						lc = (prev_q == CH_SLASH) && (item_s1.ch == CH_SLASH);
					end
					pos_d = POS_LATER;
					if (item_s1.ch == CH_QUOTE && !lc && !block_q) begin
						if (!in_string_q || prev_q != CH_BACKSLASH) begin
							str = !in_string_q;
						end
					end
					if (!str) begin
						if (prev_q == CH_SLASH && item_s1.ch == CH_STAR) begin
							blk = 1'b1;
						end
						if (prev_q == CH_STAR && item_s1.ch == CH_SLASH) begin
							blk = 1'b0;
						end
					end
				end
				block_d        = blk;
				line_comment_d = lc;
				in_string_d    = str;
				prev_d         = item_s1.ch;
				if (item_s1.line_end) begin
					res.emit       = 1'b1;
					res.is_comment = lc || blk;
					line_comment_d = 1'b0;
					in_string_d    = 1'b0;
					prev_d         = CH_NUL;
					pos_d          = POS_FIRST;
				end
			end
			CMD_EMPTY: begin
				res.emit       = 1'b1;
				res.is_comment = line_comment_q || block_q;
				line_comment_d = 1'b0;
				in_string_d    = 1'b0;
				prev_d         = CH_NUL;
				pos_d          = POS_FIRST;
			end
			CMD_EOF: begin
				block_d        = 1'b0;
				line_comment_d = 1'b0;
				in_string_d    = 1'b0;
				prev_d         = CH_NUL;
				pos_d          = POS_FIRST;
			end
			default: begin
				// Unused code: no result and no change.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q        <= 1'b0;
			in_string_q    <= 1'b0;
			line_comment_q <= 1'b0;
			prev_q         <= CH_NUL;
			pos_q          <= POS_FIRST;
		end else if (fire) begin
			block_q        <= block_d;
			in_string_q    <= in_string_d;
			line_comment_q <= line_comment_d;
			prev_q         <= prev_d;
			pos_q          <= pos_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/c_comment_line_classifier_unit.sv -----
// Top level of the C comment line classifier: input stage, scanner, result register.
// Depends on ccl_pkg, ccl_in_reg and ccl_scan.
`default_nettype none

// The block reads C source text one character per input beat and gives one
// output beat per finished line, with is_comment high when the line starts
// with two slashes or ends inside a block comment. An input beat carries cmd:
// a character (ch, with line_end marking the last one of its line), an empty
// line, or end of file, which clears all scanner state without a result; an
// empty line that arrives while a line is unfinished ends that line, with one
// result for both. The block takes one beat every clock cycle while in_stall
// is low. A taken beat sits in the input register while the scanner works on
// it, and the result of a line-ending beat is loaded into the result register
// as that beat moves on, so a result passes both registers before it leaves. The
// result register and the input register part the two sides: a new beat is
// still taken while a result waits, and input stalls only when the scanned
// beat has a result and the result register is held.
module c_comment_line_classifier_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] ch,
	input  logic       line_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       is_comment
);
	import ccl_pkg::*;

	item_t     item;
	item_t     item_s1;
	logic      valid_s1;
	logic      advance;
	logic      fire;
	scan_res_t res;
	logic      out_valid_q;
	logic      is_comment_q;

	assign item.cmd      = cmd;
	assign item.ch       = ch;
	assign item.line_end = line_end;

	// The scanned beat moves on when it has no result, or when the result
	// register is empty or is being emptied in this cycle.
	assign advance = !res.emit || !out_valid_q || !out_stall;
	assign fire    = valid_s1 && advance;

	ccl_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ccl_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.fire    (fire),
		.res     (res)
	);

	// Result register: loaded by a scanned beat that ends a line, cleared
	// when its beat is taken and nothing new arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.emit) begin
			is_comment_q <= res.is_comment;
		end
	end

	assign out_valid  = out_valid_q;
	assign is_comment = is_comment_q;

endmodule

`default_nettype wire

// ----- rtl/core/ccl_checker.sv -----
// Port-level checker for the comment line classifier, bound to the top level.
// Depends on ccl_pkg and the assertion macro header.
`default_nettype none

`include "c_comment_line_classifier_unit_macros.svh"

module ccl_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] cmd,
	input logic       line_end,
	input logic       out_valid,
	input logic       out_stall,
	input logic       is_comment
);
	import ccl_pkg::*;

	logic line_done_beat;

	// An accepted beat that finishes a line.
	assign line_done_beat = in_valid && !in_stall
		&& ((cmd == CMD_CHAR && line_end) || cmd == CMD_EMPTY);

	// A held result stays put.
	`CCL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(is_comment))

	// Input backs up only behind a result that is being held.
	`CCL_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// A result that appears on an idle output comes from a line-ending beat
	// that was taken into the input register and then scanned into the result register.
	`CCL_ASSERT_IMP(a_out_source, clk, arst_n, $rose(out_valid), $past(line_done_beat, 2))

	// A beat taken alone, with the output free, does not stall the next one.
	`CCL_ASSERT_IMP(a_no_spurious_stall, clk, arst_n, !out_valid, !in_stall)

endmodule

bind c_comment_line_classifier_unit ccl_port_checker u_ccl_checker (.*);

`default_nettype wire
